FILE: rtl/smci_pkg.sv
// Package for the soil moisture curve indicator: widths, codes, root table.
// No dependencies; used by all rtl/ modules.
package smci_pkg;
	localparam int SAMPLE_BITS = 12;
	localparam int EXP_FRAC_BITS = 8;
	localparam int EXP_BITS = 3 + EXP_FRAC_BITS;
	localparam int PCT_BITS = 7;
	localparam int COLOR_BITS = 8;
	localparam int BRIGHT_BITS = 7;
	localparam int IDX_BITS = 2;

	localparam logic [IDX_BITS-1:0] REG_WET = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_DRY = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_EXP = 2'd2;

	localparam logic [SAMPLE_BITS-1:0] WET_RESET = SAMPLE_BITS'(1300);
	localparam logic [SAMPLE_BITS-1:0] DRY_RESET = SAMPLE_BITS'(3000);
	localparam logic [EXP_BITS-1:0] EXP_RESET = EXP_BITS'((77 << EXP_FRAC_BITS) >> 8);

	// datapath operations, one per controller step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,     // latch sample, clamp, prepare divide
		OP_DIV,      // one restoring divide bit
		OP_LOGINIT,  // leading-one search result, init mantissa
		OP_SQ,       // one squaring step of log2
		OP_MUL,      // magnitude times exponent
		OP_EXPSTEP,  // one root multiply step
		OP_FINISH    // shift, percent, band, pulse
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] step;
	} cmd_t;

	typedef struct packed {
		logic dry_le_wet;
	} stat_t;

	typedef logic [16:0][32:0] root_tab_t;

	// c_0 = 1/2 in Q0.32, each next entry the truncated square root of the one before
	function automatic root_tab_t make_roots();
		root_tab_t tab;
		logic [63:0] v, res, bw;
		tab = '0;
		tab[0] = 33'h0_8000_0000;
		for (int k = 1; k <= 16; k++) begin
			v = 64'(tab[k-1]) << 32;
			res = '0;
			bw = 64'd1 << 62;
			while (bw > v) bw = bw >> 2;
			while (bw != 64'd0) begin
				if (v >= res + bw) begin
					v = v - (res + bw);
					res = (res >> 1) + bw;
				end else begin
					res = res >> 1;
				end
				bw = bw >> 2;
			end
			tab[k] = 33'(res);
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_TAB = make_roots();

	// c_k ~ 2^-(2^-k) in Q0.32
	function automatic logic [32:0] root_c(input logic [4:0] k);
		logic [32:0] r;
		if (k >= 5'd1 && k <= 5'd16) r = ROOT_TAB[k];
		else r = 33'h1_0000_0000;
		return r;
	endfunction
endpackage

FILE: rtl/smci_ctrl.sv
// Controller of the soil moisture curve indicator: sequences the datapath steps.
// Depends on smci_pkg.
module smci_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output smci_pkg::cmd_t cmd
);
	import smci_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DIV   = 7'b0000010,
		S_LOGI  = 7'b0000100,
		S_SQ    = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_EXP   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [4:0] cnt_q;
	logic out_valid_q;

	// output register may hold a result while the next item is being worked
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	logic fin_ok;
	assign fin_ok = !out_valid_q || !out_stall;

	always_comb begin
		cmd.step = cnt_q;
		unique case (state_q)
			S_IDLE: cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_DIV:  cmd.op = OP_DIV;
			S_LOGI: cmd.op = OP_LOGINIT;
			S_SQ:   cmd.op = OP_SQ;
			S_MUL:  cmd.op = OP_MUL;
			S_EXP:  cmd.op = OP_EXPSTEP;
			S_FIN:  cmd.op = fin_ok ? OP_FINISH : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_DIV;
					cnt_q <= '0;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= S_LOGI;
						cnt_q <= '0;
					end
				end
				S_LOGI: state_q <= S_SQ;
				S_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						state_q <= S_MUL;
						cnt_q <= 5'd1;
					end
				end
				S_MUL: state_q <= S_EXP;
				S_EXP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) state_q <= S_FIN;
				end
				S_FIN: if (fin_ok) begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("accept while busy");
	a_fin_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINISH) |-> (!out_valid_q || !out_stall))
		else $error("result overwritten");
	a_valid_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FINISH) |=> out_valid_q) else $error("result lost");
endmodule

FILE: rtl/smci_datapath.sv
// Datapath of the soil moisture curve indicator: divide, log2, power, percent.
// Depends on smci_pkg; driven by smci_ctrl commands.
module smci_datapath (
	input  logic clk,
	input  logic arst_n,
	input  smci_pkg::cmd_t cmd,
	input  logic [smci_pkg::SAMPLE_BITS-1:0] raw_sample,
	input  logic [smci_pkg::SAMPLE_BITS-1:0] wet_level,
	input  logic [smci_pkg::SAMPLE_BITS-1:0] dry_level,
	input  logic [smci_pkg::EXP_BITS-1:0] curve_exponent,
	output smci_pkg::stat_t stat,
	output logic [smci_pkg::PCT_BITS-1:0] moisture_percent,
	output logic [smci_pkg::COLOR_BITS-1:0] red_level,
	output logic [smci_pkg::COLOR_BITS-1:0] green_level,
	output logic [smci_pkg::COLOR_BITS-1:0] blue_level,
	output logic [smci_pkg::BRIGHT_BITS-1:0] led_brightness
);
	import smci_pkg::*;

	localparam int NB = SAMPLE_BITS + 17;

	logic [NB-1:0] num_q;          // shifted dividend: low bit, then zero fill
	logic [SAMPLE_BITS:0] rem_q;
	logic [SAMPLE_BITS-1:0] den_q;
	logic [16:0] n_q;              // quotient 0..65536
	logic [4:0] p_q;
	logic [31:0] m_q;              // Q1.30 (plus headroom)
	logic [15:0] frac_q;
	logic [33:0] t_q;
	logic [32:0] v_q;
	logic special_one_q, special_zero_q;
	logic [6:0] pulse_q;
	logic rising_q;

	assign stat.dry_le_wet = (dry_level <= wet_level);

	// clamp
	logic [SAMPLE_BITS-1:0] rc;
	always_comb begin
		rc = raw_sample;
		if (rc < wet_level) rc = wet_level;
		if (rc > dry_level) rc = dry_level;
	end

	// divide step
	logic [SAMPLE_BITS+1:0] trial;
	assign trial = {rem_q, num_q[NB-1]} - {2'b00, den_q};

	// leading one of n (bits 15..0)
	logic [4:0] lead;
	always_comb begin
		lead = 5'd0;
		for (int i = 0; i < 16; i++) if (n_q[i]) lead = 5'(i);
	end

	logic [63:0] sq;
	assign sq = (64'(m_q) * 64'(m_q)) >> 30;

	logic [33:0] mag;
	assign mag = 34'(({5'd0, 5'd16 - p_q} << 16) - 34'(frac_q));
	logic [44:0] mt;
	assign mt = 45'(mag) * 45'(curve_exponent);

	logic [65:0] vm;
	assign vm = 66'(v_q) * 66'(root_c(cmd.step));

	// finish
	logic [32:0] y;
	logic [17:0] q;
	logic [39:0] pr;
	logic [6:0] pct;
	logic [7:0] lvl;
	always_comb begin
		q = 18'(t_q >> 16);
		if (special_one_q) y = 33'h1_0000_0000;
		else if (special_zero_q || q > 18'd32) y = '0;
		else y = v_q >> q[5:0];
		pr = 40'(7'd100) * 40'(33'h1_0000_0000 - y);
		pct = (pr[39:32] > 8'd100) ? 7'd100 : 7'(pr[39:32]);
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				// difference is at most the span: first step compares it whole
				num_q <= NB'(rc - wet_level) << (NB - 1);
				den_q <= dry_level - wet_level;
				rem_q <= (SAMPLE_BITS+1)'((rc - wet_level) >> 1);
				n_q <= '0;
				special_one_q <= (curve_exponent == '0);
			end
			OP_DIV: begin
				num_q <= num_q << 1;
				if (!trial[SAMPLE_BITS+1]) begin
					rem_q <= trial[SAMPLE_BITS:0];
					n_q <= {n_q[15:0], 1'b1};
				end else begin
					rem_q <= {rem_q[SAMPLE_BITS-1:0], num_q[NB-1]};
					n_q <= {n_q[15:0], 1'b0};
				end
			end
			OP_LOGINIT: begin
				if (stat.dry_le_wet) begin
					special_zero_q <= !special_one_q;
				end else begin
					special_one_q <= special_one_q || n_q[16];
					special_zero_q <= (n_q == '0);
				end
				p_q <= lead;
				m_q <= 32'({n_q[15:0], 16'd0} >> lead) << 14;
				frac_q <= '0;
			end
			OP_SQ: begin
				if (sq[31]) begin
					m_q <= 32'(sq >> 1);
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q <= sq[31:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			OP_MUL: begin
				t_q <= 34'(mt >> EXP_FRAC_BITS);
				v_q <= 33'h1_0000_0000;
			end
			OP_EXPSTEP: begin
				if (t_q[5'd16 - cmd.step]) v_q <= 33'(vm >> 32);
			end
			default: ;
		endcase
	end

	// output register and pulse state
	always_comb begin
		lvl = rising_q ? 8'(pulse_q) + 8'd8 : 8'(pulse_q) - 8'd8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= 7'd16;
			rising_q <= 1'b1;
		end else if (cmd.op == OP_FINISH) begin
			if (pct >= 7'd55 && pct <= 7'd70) begin
				if (lvl >= 8'd48 || lvl <= 8'd8) begin
					rising_q <= !rising_q;
					pulse_q <= (lvl < 8'd8) ? 7'd8 : (lvl > 8'd64) ? 7'd64 : 7'(lvl);
				end else pulse_q <= 7'(lvl);
			end else pulse_q <= 7'd8;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FINISH) begin
			moisture_percent <= pct;
			priority if (pct < 7'd10) {red_level, green_level, blue_level} <= 24'hFF0000;
			else if (pct < 7'd25) {red_level, green_level, blue_level} <= 24'hFF4000;
			else if (pct < 7'd40) {red_level, green_level, blue_level} <= 24'hFF8000;
			else if (pct < 7'd55) {red_level, green_level, blue_level} <= 24'h80FF00;
			else if (pct < 7'd70) {red_level, green_level, blue_level} <= 24'h00FF00;
			else if (pct < 7'd85) {red_level, green_level, blue_level} <= 24'h00FF80;
			else {red_level, green_level, blue_level} <= 24'h0000FF;
		end
	end
	assign led_brightness = pulse_q;

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_q <= 7'd64) else $error("pulse out of range");
	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SQ) |=> (m_q < 32'h8000_0000)) else $error("mantissa overflow");
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.op == OP_FINISH) |-> (moisture_percent <= 7'd100))
		else $error("percent out of range");
endmodule

FILE: rtl/soil_moisture_curve_indicator_unit.sv
// Top level of the soil moisture curve indicator: config registers, controller, datapath.
// Depends on smci_pkg, smci_ctrl, smci_datapath.
//
//  channel | signals                                   | transfer when
//  input   | in_valid, in_stall, raw_sample            | in_valid && !in_stall
//  output  | out_valid, out_stall, result fields       | out_valid && !out_stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// Each item passes in turn through the serial divider, the 16 log2 squarings
// and 16 root multiplies on one shared datapath; no new item is taken until it finishes.
// Result waits in the output register; the next item may start meanwhile.
// Reset: wet 1300, dry 3000, exponent 77, pulse level 16 rising.
module soil_moisture_curve_indicator_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [smci_pkg::SAMPLE_BITS-1:0] raw_sample,
	output logic out_valid,
	input  logic out_stall,
	output logic [smci_pkg::PCT_BITS-1:0] moisture_percent,
	output logic [smci_pkg::COLOR_BITS-1:0] red_level,
	output logic [smci_pkg::COLOR_BITS-1:0] green_level,
	output logic [smci_pkg::COLOR_BITS-1:0] blue_level,
	output logic [smci_pkg::BRIGHT_BITS-1:0] led_brightness,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [smci_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import smci_pkg::*;

	logic [SAMPLE_BITS-1:0] wet_q, dry_q;
	logic [EXP_BITS-1:0] exp_q;
	cmd_t cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	// register writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_q <= WET_RESET;
			dry_q <= DRY_RESET;
			exp_q <= EXP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WET: wet_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_DRY: dry_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_EXP: exp_q <= cfg_data[EXP_BITS-1:0];
				default: ;
			endcase
		end
	end

	smci_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
	);

	smci_datapath u_dp (
		.clk, .arst_n, .cmd, .raw_sample,
		.wet_level(wet_q), .dry_level(dry_q), .curve_exponent(exp_q),
		.stat, .moisture_percent, .red_level, .green_level, .blue_level,
		.led_brightness
	);
endmodule
